// ===== rtl/modem_socket_response_parser_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef MODEM_SOCKET_RESPONSE_PARSER_ASSERT_SVH
`define MODEM_SOCKET_RESPONSE_PARSER_ASSERT_SVH

// Same-cycle check, ignored while reset is held.
`define MSRP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle check: when ante holds, cons must hold in the next cycle.
`define MSRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ===== rtl/msrp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msrp_pkg;

    localparam int BUF_DEPTH_DEF = 1024;
    localparam int CNT_W         = 14;
    localparam int IDX_W         = 10;

    typedef enum logic [1:0] {
        FUNC_NOTIFY = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_ACK    = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    // Bit positions inside the acknowledge mask.
    localparam int ACK_READY  = 0;
    localparam int ACK_AVAIL  = 1;
    localparam int ACK_CLOSED = 2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] position;
        logic [7:0] byte_in;
        logic       read_busy;
        logic [2:0] ack_mask;
    } t_item;

    typedef struct packed {
        logic             notify_armed;
        logic             avail_pending;
        logic [3:0]       avail_sock;
        logic             closed_pending;
        logic [3:0]       closed_sock;
        logic [3:0]       rx_sock;
        logic [CNT_W-1:0] rx_length;
        logic             rx_ready;
        logic             capturing;
        logic [CNT_W-1:0] capture_count;
    } t_state;

    typedef struct packed {
        logic             keep_going;
        logic             store_valid;
        logic [IDX_W-1:0] store_index;
        logic [7:0]       store_byte;
        logic             data_ready;
        logic [3:0]       data_socket;
        logic [CNT_W-1:0] data_length;
        logic             avail_flag;
        logic [3:0]       avail_socket;
        logic             closed_flag;
        logic [3:0]       closed_socket;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/modem_socket_response_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Parser for modem socket-read responses and socket notifications.
// Input channel: one received character per word, with its function code,
// position after the matched prefix, busy flag and acknowledge mask; a word
// is taken when i_in_valid is high and o_in_stall is low.
// Output channel: one result word per input word, in order, with the
// continue flag, an optional payload byte to store at its buffer index, and
// the current data-ready, data-available and socket-closed flags with their
// socket numbers and the announced length.
// A word is captured in the input register, is parsed against the state
// registers and lands in the output register. Throughput is one word
// per cycle when the output is not stalled; the state update is a single pass of
// compares and a constant multiply by ten on the 14-bit length.
// When the receiver holds i_out_stall, the output word stays put and the
// input register still fills; o_in_stall rises only when both are full.
// Synchronous reset clears all flags, sockets, the length and the capture
// counter, and empties both registers.
// Payload bytes at or beyond BUF_DEPTH are counted but not stored.

module modem_socket_response_parser #(
    parameter int BUF_DEPTH = msrp_pkg::BUF_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [3:0]  i_position,
    input  wire logic [7:0]  i_byte_in,
    input  wire logic        i_read_busy,
    input  wire logic [2:0]  i_ack_mask,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_keep_going,
    output logic             o_store_valid,
    output logic [9:0]       o_store_index,
    output logic [7:0]       o_store_byte,
    output logic             o_data_ready,
    output logic [3:0]       o_data_socket,
    output logic [13:0]      o_data_length,
    output logic             o_avail_flag,
    output logic [3:0]       o_avail_socket,
    output logic             o_closed_flag,
    output logic [3:0]       o_closed_socket
);

    logic             r_in_valid;
    msrp_pkg::t_item  r_in;
    msrp_pkg::t_state r_state;
    msrp_pkg::t_state n_state;
    logic             r_out_valid;
    msrp_pkg::t_out   r_out;
    msrp_pkg::t_out   n_out;
    logic             out_free;
    logic             advance;
    logic             in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    msrp_step #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_step (
        .i_item  (r_in),
        .i_state (r_state),
        .o_state (n_state),
        .o_out   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.func      <= i_func;
            r_in.position  <= i_position;
            r_in.byte_in   <= i_byte_in;
            r_in.read_busy <= i_read_busy;
            r_in.ack_mask  <= i_ack_mask;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_keep_going    = r_out.keep_going;
    assign o_store_valid   = r_out.store_valid;
    assign o_store_index   = r_out.store_index;
    assign o_store_byte    = r_out.store_byte;
    assign o_data_ready    = r_out.data_ready;
    assign o_data_socket   = r_out.data_socket;
    assign o_data_length   = r_out.data_length;
    assign o_avail_flag    = r_out.avail_flag;
    assign o_avail_socket  = r_out.avail_socket;
    assign o_closed_flag   = r_out.closed_flag;
    assign o_closed_socket = r_out.closed_socket;

endmodule

`default_nettype wire

// ===== rtl/msrp_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msrp_step #(
    parameter int BUF_DEPTH = msrp_pkg::BUF_DEPTH_DEF
) (
    input  msrp_pkg::t_item  i_item,
    input  msrp_pkg::t_state i_state,
    output msrp_pkg::t_state o_state,
    output msrp_pkg::t_out   o_out
);

    localparam logic [msrp_pkg::CNT_W:0] DEPTH_LIM = (msrp_pkg::CNT_W + 1)'(BUF_DEPTH);

    msrp_pkg::t_state                  ns;
    logic                              go;
    logic                              sv;
    logic [msrp_pkg::IDX_W-1:0]        si;
    logic [7:0]                        sb;
    logic [7:0]                        c;
    logic [3:0]                        pos;
    logic                              is_dig;
    logic                              is_nz_dig;
    logic [2:0]                        nd;
    logic [3:0]                        nd_p3;
    logic [3:0]                        nd_p4;
    logic [msrp_pkg::CNT_W-1:0]        len_x10;
    logic [msrp_pkg::CNT_W-1:0]        cnt_inc;

    assign c         = i_item.byte_in;
    assign pos       = i_item.position;
    assign is_dig    = (c >= msrp_pkg::CH_ZERO) && (c <= msrp_pkg::CH_NINE);
    assign is_nz_dig = (c >= msrp_pkg::CH_ONE) && (c <= msrp_pkg::CH_NINE);

    // Number of decimal digits already taken into the length.
    always_comb begin
        if (i_state.rx_length == '0) begin
            nd = 3'd0;
        end else if (i_state.rx_length < 14'd10) begin
            nd = 3'd1;
        end else if (i_state.rx_length < 14'd100) begin
            nd = 3'd2;
        end else if (i_state.rx_length < 14'd1000) begin
            nd = 3'd3;
        end else begin
            nd = 3'd4;
        end
    end

    assign nd_p3   = {1'b0, nd} + 4'd3;
    assign nd_p4   = {1'b0, nd} + 4'd4;
    assign len_x10 = {i_state.rx_length[msrp_pkg::CNT_W-4:0], 3'b000}
                   + {i_state.rx_length[msrp_pkg::CNT_W-2:0], 1'b0}
                   + {{(msrp_pkg::CNT_W-4){1'b0}}, c[3:0]};
    assign cnt_inc = i_state.capture_count + 1'b1;

    always_comb begin
        ns = i_state;
        go = 1'b0;
        sv = 1'b0;
        si = '0;
        sb = '0;
        unique case (msrp_pkg::t_func'(i_item.func))
            msrp_pkg::FUNC_NOTIFY: begin
                if (!i_item.read_busy) begin
                    case (pos)
                        4'd0: begin
                            if (is_dig) begin
                                ns.avail_sock    = c[3:0];
                                ns.closed_sock   = c[3:0];
                                ns.avail_pending = 1'b0;
                                ns.notify_armed  = 1'b0;
                                go               = 1'b1;
                            end
                        end
                        4'd1: go = (c == msrp_pkg::CH_COMMA);
                        4'd2: go = (c == msrp_pkg::CH_SPACE);
                        4'd3: begin
                            if (c == msrp_pkg::CH_ONE) begin
                                ns.notify_armed = 1'b1;
                                go              = 1'b1;
                            end else if (c == msrp_pkg::CH_TWO) begin
                                ns.notify_armed   = 1'b0;
                                ns.closed_pending = 1'b1;
                                go                = 1'b1;
                            end else begin
                                go = (c == msrp_pkg::CH_DASH);
                            end
                        end
                        4'd4: begin
                            if (i_state.notify_armed && c == msrp_pkg::CH_CR) begin
                                ns.avail_pending = 1'b1;
                            end else begin
                                ns.avail_pending = 1'b0;
                                if (c == msrp_pkg::CH_TWO) begin
                                    ns.closed_pending = 1'b1;
                                end
                            end
                            ns.notify_armed = 1'b0;
                        end
                        default: go = 1'b1;
                    endcase
                end
            end
            msrp_pkg::FUNC_READ: begin
                if (pos == 4'd0) begin
                    // A fresh header always ends any capture in progress.
                    ns.capturing = 1'b0;
                    if (is_dig) begin
                        ns.rx_sock = c[3:0];
                    end
                    go = 1'b1;
                end else if (i_state.capturing) begin
                    if ({1'b0, i_state.capture_count} < DEPTH_LIM) begin
                        sv = 1'b1;
                        si = i_state.capture_count[msrp_pkg::IDX_W-1:0];
                        sb = c;
                    end
                    ns.capture_count = cnt_inc;
                    if (cnt_inc >= i_state.rx_length) begin
                        ns.rx_ready  = 1'b1;
                        ns.capturing = 1'b0;
                    end else begin
                        go = 1'b1;
                    end
                end else if (pos == 4'd1) begin
                    go = (c == msrp_pkg::CH_COMMA);
                end else if (pos == 4'd2) begin
                    if (c == msrp_pkg::CH_SPACE) begin
                        ns.rx_length = '0;
                        go           = 1'b1;
                    end
                end else if (pos == 4'd3) begin
                    if (is_nz_dig) begin
                        ns.rx_length = {{(msrp_pkg::CNT_W-4){1'b0}}, c[3:0]};
                        go           = 1'b1;
                    end else if (c == msrp_pkg::CH_DASH) begin
                        ns.closed_pending = 1'b1;
                        ns.closed_sock    = i_state.rx_sock;
                    end
                end else if (is_dig) begin
                    // A further digit must sit right after the earlier ones.
                    if (pos <= 4'd6 && pos == nd_p3) begin
                        ns.rx_length = len_x10;
                        go           = 1'b1;
                    end
                end else if (nd != 3'd0) begin
                    if (c == msrp_pkg::CH_CR) begin
                        go = (pos == nd_p3);
                    end else if (c == msrp_pkg::CH_LF && pos == nd_p4) begin
                        ns.capturing     = 1'b1;
                        ns.capture_count = '0;
                        go               = 1'b1;
                    end
                end
            end
            msrp_pkg::FUNC_ACK: begin
                if (i_item.ack_mask[msrp_pkg::ACK_READY]) begin
                    ns.rx_ready = 1'b0;
                end
                if (i_item.ack_mask[msrp_pkg::ACK_AVAIL]) begin
                    ns.avail_pending = 1'b0;
                end
                if (i_item.ack_mask[msrp_pkg::ACK_CLOSED]) begin
                    ns.closed_pending = 1'b0;
                end
            end
            msrp_pkg::FUNC_NONE: begin
            end
        endcase
    end

    assign o_state = ns;

    always_comb begin
        o_out.keep_going    = go;
        o_out.store_valid   = sv;
        o_out.store_index   = si;
        o_out.store_byte    = sb;
        o_out.data_ready    = ns.rx_ready;
        o_out.data_socket   = ns.rx_sock;
        o_out.data_length   = ns.rx_length;
        o_out.avail_flag    = ns.avail_pending;
        o_out.avail_socket  = ns.avail_sock;
        o_out.closed_flag   = ns.closed_pending;
        o_out.closed_socket = ns.closed_sock;
    end

endmodule

`default_nettype wire

// ===== rtl/msrp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "modem_socket_response_parser_assert.svh"

module msrp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_keep_going,
    input wire logic        o_store_valid,
    input wire logic [9:0]  o_store_index,
    input wire logic [7:0]  o_store_byte,
    input wire logic [3:0]  o_data_socket,
    input wire logic [13:0] o_data_length,
    input wire logic [3:0]  o_avail_socket,
    input wire logic [3:0]  o_closed_socket
);

    // A stalled result word keeps its payload.
    `MSRP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_store_byte) && $stable(o_store_index) && $stable(o_keep_going), "stalled result word changed")

    // The input side only backs up when the output register is full and held.
    `MSRP_ASSERT(a_in_stall_cause, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall), "input stalled with free output")

    // Payload is only stored after a nonzero length was parsed.
    `MSRP_ASSERT(a_store_len, i_clk, i_rst_n, (o_out_valid && o_store_valid) |-> (o_data_length != 14'd0), "payload stored with no length")

    // Socket numbers come from single decimal digits.
    `MSRP_ASSERT(a_sock_range, i_clk, i_rst_n, o_out_valid |-> (o_data_socket <= 4'd9 && o_avail_socket <= 4'd9 && o_closed_socket <= 4'd9), "socket number out of range")

endmodule

bind modem_socket_response_parser msrp_checker u_msrp_checker (.*);

`default_nettype wire
